/* sv/jsu_pkg.sv */
`default_nettype none
package jsu_pkg;

  // Parser scan modes
  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_BODY = 3'd1,
    MODE_ESC  = 3'd2,
    MODE_HEX  = 3'd3,
    MODE_ERR  = 3'd4
  } mode_t;

  // Result kinds
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_EXPECT_QUOTE = 3'd0;
  localparam logic [2:0] ERR_UNTERM_ESC   = 3'd1;
  localparam logic [2:0] ERR_BAD_ESC      = 3'd2;
  localparam logic [2:0] ERR_BAD_UNICODE  = 3'd3;
  localparam logic [2:0] ERR_UNTERM_STR   = 3'd4;

  // Most results one input byte can cause
  localparam int unsigned MAX_RESULTS = 3;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_end;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic [2:0] error_code;
    logic       last;
  } out_beat_t;

endpackage
`default_nettype wire

/* sv/jsu_in_if.sv */
`default_nettype none
interface jsu_in_if;
  import jsu_pkg::*;

  logic     valid;
  logic     ready;
  in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/jsu_out_if.sv */
`default_nettype none
interface jsu_out_if;
  import jsu_pkg::*;

  logic      valid;
  logic      ready;
  out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/json_string_unescape_unit.sv */
`default_nettype none
// Streaming JSON string unescaper with UTF-8 output of \u escapes.
// Latency: the first result of a byte is presented the cycle after the byte is taken.
// Throughput: one byte per cycle while each byte gives at most one result and the output
// is not stalled; a byte that gives more results holds the input while the result buffer drains.
// Reset (rst_n low, synchronous): idle seeking an opening quote, result buffer empty.
module json_string_unescape_unit (
  input  wire        clk,
  input  wire        rst_n,
  jsu_in_if.sink     in_chan,
  jsu_out_if.source  out_chan
);
  import jsu_pkg::*;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_F = 8'h66;
  localparam logic [7:0] CH_N = 8'h6E;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_U = 8'h75;

  mode_t       mode_r, mode_nxt;
  logic [1:0]  hex_cnt_r, hex_cnt_nxt;
  logic [15:0] cp_r, cp_nxt;

  out_beat_t   buf_r [MAX_RESULTS];
  logic [1:0]  cnt_r;

  out_beat_t   res [MAX_RESULTS];
  logic [1:0]  res_cnt;

  logic        accept;
  logic        pop;
  logic [7:0]  c;
  logic        is_end;
  logic        hex_ok;
  logic [3:0]  hex_val;
  logic [15:0] cp_new;

  assign c      = in_chan.data.text_byte;
  assign is_end = in_chan.data.text_end;
  assign pop    = out_chan.valid && out_chan.ready;
  // take a new byte once the buffer is empty or about to be
  assign in_chan.ready = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_chan.ready);
  assign accept = in_chan.valid && in_chan.ready;

  assign out_chan.valid = (cnt_r != 2'd0);
  assign out_chan.data  = buf_r[0];

  // decode one hex digit
  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      hex_val = c[3:0];
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      hex_val = c[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign cp_new = {cp_r[11:0], hex_val};

  // next state
  always_comb begin
    mode_nxt    = mode_r;
    hex_cnt_nxt = hex_cnt_r;
    cp_nxt      = cp_r;
    if (is_end) begin
      mode_nxt    = MODE_IDLE;
      hex_cnt_nxt = 2'd0;
    end else begin
      case (mode_r)
        MODE_IDLE: begin
          if (c == CH_QUOTE) begin
            mode_nxt = MODE_BODY;
          end else if (!(c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF})) begin
            mode_nxt = MODE_ERR;
          end
        end
        MODE_BODY: begin
          if (c == CH_QUOTE) begin
            mode_nxt = MODE_IDLE;
          end else if (c == CH_BSLASH) begin
            mode_nxt = MODE_ESC;
          end
        end
        MODE_ESC: begin
          if (c inside {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T}) begin
            mode_nxt = MODE_BODY;
          end else if (c == CH_U) begin
            mode_nxt    = MODE_HEX;
            hex_cnt_nxt = 2'd0;
            cp_nxt      = 16'd0;
          end else begin
            mode_nxt = MODE_ERR;
          end
        end
        MODE_HEX: begin
          if (!hex_ok) begin
            hex_cnt_nxt = 2'd0;
            mode_nxt    = MODE_ERR;
          end else begin
            cp_nxt      = cp_new;
            hex_cnt_nxt = hex_cnt_r + 2'd1;
            if (hex_cnt_r == 2'd3) begin
              mode_nxt = MODE_BODY;
            end
          end
        end
        default: begin
          mode_nxt = MODE_ERR;
        end
      endcase
    end
  end

  // results for the byte
  always_comb begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      res[i] = '0;
    end
    res_cnt = 2'd0;
    if (is_end) begin
      case (mode_r)
        MODE_BODY: begin
          res[0].out_kind   = KIND_ERROR;
          res[0].error_code = ERR_UNTERM_STR;
          res_cnt           = 2'd1;
        end
        MODE_ESC: begin
          res[0].out_kind   = KIND_ERROR;
          res[0].error_code = ERR_UNTERM_ESC;
          res_cnt           = 2'd1;
        end
        MODE_HEX: begin
          res[0].out_kind   = KIND_ERROR;
          res[0].error_code = ERR_BAD_UNICODE;
          res_cnt           = 2'd1;
        end
        default: begin
          res_cnt = 2'd0;
        end
      endcase
    end else begin
      case (mode_r)
        MODE_IDLE: begin
          if (c != CH_QUOTE && !(c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF})) begin
            res[0].out_kind   = KIND_ERROR;
            res[0].error_code = ERR_EXPECT_QUOTE;
            res_cnt           = 2'd1;
          end
        end
        MODE_BODY: begin
          if (c == CH_QUOTE) begin
            res[0].out_kind = KIND_CLOSE;
            res_cnt         = 2'd1;
          end else if (c != CH_BSLASH) begin
            res[0].out_kind = KIND_BYTE;
            res[0].out_byte = c;
            res_cnt         = 2'd1;
          end
        end
        MODE_ESC: begin
          res[0].out_kind = KIND_BYTE;
          res_cnt         = 2'd1;
          case (c)
            CH_QUOTE, CH_BSLASH, CH_SLASH: res[0].out_byte = c;
            CH_B: res[0].out_byte = 8'h08;
            CH_F: res[0].out_byte = 8'h0C;
            CH_N: res[0].out_byte = 8'h0A;
            CH_R: res[0].out_byte = 8'h0D;
            CH_T: res[0].out_byte = 8'h09;
            CH_U: res_cnt = 2'd0;
            default: begin
              res[0].out_kind   = KIND_ERROR;
              res[0].error_code = ERR_BAD_ESC;
            end
          endcase
        end
        MODE_HEX: begin
          if (!hex_ok) begin
            res[0].out_kind   = KIND_ERROR;
            res[0].error_code = ERR_BAD_UNICODE;
            res_cnt           = 2'd1;
          end else if (hex_cnt_r == 2'd3) begin
            // encode the finished code point as UTF-8
            if (cp_new[15:7] == 9'd0) begin
              res[0].out_byte = {1'b0, cp_new[6:0]};
              res_cnt         = 2'd1;
            end else if (cp_new[15:11] == 5'd0) begin
              res[0].out_byte = {3'b110, cp_new[10:6]};
              res[1].out_byte = {2'b10, cp_new[5:0]};
              res_cnt         = 2'd2;
            end else begin
              res[0].out_byte = {4'b1110, cp_new[15:12]};
              res[1].out_byte = {2'b10, cp_new[11:6]};
              res[2].out_byte = {2'b10, cp_new[5:0]};
              res_cnt         = 2'd3;
            end
          end
        end
        default: begin
          res_cnt = 2'd0;
        end
      endcase
    end
    // flag the final result of this byte
    for (int i = 0; i < MAX_RESULTS; i++) begin
      res[i].last = (res_cnt == 2'(i + 1));
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IDLE;
      hex_cnt_r <= 2'd0;
      cp_r      <= 16'd0;
    end else if (accept) begin
      mode_r    <= mode_nxt;
      hex_cnt_r <= hex_cnt_nxt;
      cp_r      <= cp_nxt;
    end
  end

  // result buffer fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (accept) begin
      cnt_r <= res_cnt;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  // load results or advance to the next beat
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        buf_r[i] <= res[i];
      end
    end else if (pop) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        buf_r[i] <= buf_r[i + 1];
      end
    end
  end

endmodule
`default_nettype wire
